// ----- src/lkxc_pkg.sv -----
// Shared types and constants for the LCG keystream XOR cipher.
`default_nettype none
package lkxc_pkg;

  localparam int WORD_W  = 64;
  localparam int HALF_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 3;
  localparam int CFG_IDX_W = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POS_W-1:0]  pos_t;

  localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MULT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INCR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIX  = 2'd3;

  // Sequencer values of the key recalculation after reset or a register write.
  localparam logic [2:0] CAL_START = 3'd4;
  localparam logic [2:0] CAL_NEXT  = 3'd3;

endpackage
`default_nettype wire

// ----- src/lcg_keystream_xor_cipher.sv -----
// Top level of the LCG keystream XOR cipher with its advance multiplier and output skid stage.
`default_nettype none
// One byte is transformed per cycle while in_stall is low: each byte is XORed with a
// byte of a 64-bit generator word that is always ready in a register, and its result
// is registered and offered the cycle after the byte is taken, or waits in the skid
// stage while the output stalls. The next generator word (state * multiplier +
// increment) is worked out ahead by a two-stage multiplier of three 32x32 partial
// products; the word for a message start is held precomputed. After reset, and from
// a register write until the recalculation sequencer has counted down, in_stall is
// high while these words are recalculated. Otherwise a byte is taken in every cycle;
// while a result waits, one more byte goes into the skid stage and in_stall then
// stays high until the waiting result has been transferred.
module lcg_keystream_xor_cipher
  import lkxc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BYTE_W-1:0]    in_data_byte,
  input  wire logic                 in_message_start,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [BYTE_W-1:0]         out_result_byte
);

  word_t seed_r, mult_r, incr_r, mix_r;
  word_t mult_eff, incr_eff;

  word_t cur_r, cur_nxt;
  word_t nxt_r, nxt_nxt;
  word_t k0_r, k0_nxt;
  pos_t  pos_r, pos_nxt, pos_use;
  logic  upd_r, upd_nxt;
  logic [2:0] cal_r, cal_nxt;

  logic  s1_vld_r, s1_vld_nxt;
  logic  s1_k0_r, s1_k0_nxt;
  word_t p_ll_r, p_ll_nxt;
  logic [HALF_W-1:0] p_lh_r, p_lh_nxt, p_hl_r, p_hl_nxt;
  logic [HALF_W-1:0] prod_lh, prod_hl;
  word_t mul_x, prod_ll, adv_sum;
  logic  issue, issue_k0;

  logic  out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;
  byte_t out_byte_r, out_byte_nxt, skid_byte_r, skid_byte_nxt;
  byte_t res_byte;
  word_t word_use;
  logic  acc, grp_new, out_free;

  assign mult_eff = {mult_r[WORD_W-1:1], 1'b1};
  assign incr_eff = {incr_r[WORD_W-1:1], 1'b1};

  // Input side and keystream selection.
  assign in_stall = (cal_r != 3'd0) || skid_vld_r || cfg_we;
  assign acc      = in_valid && !in_stall;
  assign grp_new  = in_message_start || (pos_r == '0);
  assign pos_use  = in_message_start ? '0 : pos_r;

  always_comb begin
    if (in_message_start) begin
      word_use = k0_r;
    end else if (pos_r == '0) begin
      word_use = nxt_r;
    end else begin
      word_use = cur_r;
    end
  end

  assign res_byte = in_data_byte ^ word_use[{pos_use, 3'b000} +: BYTE_W];

  always_comb begin
    cur_nxt = cur_r;
    pos_nxt = pos_r;
    upd_nxt = 1'b0;
    if (acc) begin
      pos_nxt = pos_use + pos_t'(1);
      if (grp_new) begin
        cur_nxt = word_use;
        upd_nxt = 1'b1;
      end
    end
  end

  // Recalculation sequencer and advance multiplier.
  always_comb begin
    cal_nxt = cal_r;
    if (cfg_we) begin
      cal_nxt = CAL_START;
    end else if (cal_r != 3'd0) begin
      cal_nxt = cal_r - 3'd1;
    end
  end

  assign issue_k0 = (cal_r == CAL_START) && !cfg_we;
  assign issue    = issue_k0 || ((cal_r == CAL_NEXT) && !cfg_we) || upd_r;
  assign mul_x    = issue_k0 ? (seed_r ^ mix_r) : cur_r;

  assign prod_ll = word_t'(mul_x[HALF_W-1:0]) * word_t'(mult_eff[HALF_W-1:0]);
  assign prod_lh = mul_x[HALF_W-1:0] * mult_eff[WORD_W-1:HALF_W];
  assign prod_hl = mul_x[WORD_W-1:HALF_W] * mult_eff[HALF_W-1:0];

  assign s1_vld_nxt = issue;
  assign s1_k0_nxt  = issue_k0;
  assign p_ll_nxt   = prod_ll;
  assign p_lh_nxt   = prod_lh;
  assign p_hl_nxt   = prod_hl;

  assign adv_sum = p_ll_r + {p_lh_r + p_hl_r, {HALF_W{1'b0}}} + incr_eff;

  always_comb begin
    k0_nxt  = k0_r;
    nxt_nxt = nxt_r;
    if (s1_vld_r) begin
      if (s1_k0_r) begin
        k0_nxt = adv_sum;
      end else begin
        nxt_nxt = adv_sum;
      end
    end
  end

  // Output register with a skid stage behind it.
  assign out_free = !out_vld_r || !out_stall;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_byte_nxt  = out_byte_r;
    skid_vld_nxt  = skid_vld_r;
    skid_byte_nxt = skid_byte_r;
    if (out_free) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_byte_nxt = skid_byte_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt  = acc;
        out_byte_nxt = res_byte;
      end
    end else if (acc) begin
      skid_vld_nxt  = 1'b1;
      skid_byte_nxt = res_byte;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_result_byte = out_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= '0;
      mult_r     <= '0;
      incr_r     <= '0;
      mix_r      <= '0;
      cur_r      <= '0;
      pos_r      <= '0;
      upd_r      <= 1'b0;
      cal_r      <= CAL_START;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SEED: seed_r <= cfg_data;
          REG_MULT: mult_r <= cfg_data;
          REG_INCR: incr_r <= cfg_data;
          REG_MIX:  mix_r  <= cfg_data;
          default:  ;
        endcase
      end
      cur_r      <= cur_nxt;
      pos_r      <= pos_nxt;
      upd_r      <= upd_nxt;
      cal_r      <= cal_nxt;
      s1_vld_r   <= s1_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_k0_r     <= s1_k0_nxt;
    p_ll_r      <= p_ll_nxt;
    p_lh_r      <= p_lh_nxt;
    p_hl_r      <= p_hl_nxt;
    k0_r        <= k0_nxt;
    nxt_r       <= nxt_nxt;
    out_byte_r  <= out_byte_nxt;
    skid_byte_r <= skid_byte_nxt;
  end

  // A byte that opens a new group must find the next generator word settled.
  assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_message_start && (pos_r == '0)) |-> (!s1_vld_r && !upd_r))
    else $error("generator word used before its advance completed");

  // No byte is taken while the key words are being recalculated.
  assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ((cal_r == 3'd0) && !s1_k0_r))
    else $error("byte accepted during key recalculation");

  // The skid stage only fills behind a waiting result.
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid stage holds a byte while the output is empty");

  // A waiting result is released from the skid stage in order.
  assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && !out_stall) |=> (out_vld_r && (out_byte_r == $past(skid_byte_r))))
    else $error("skid byte lost or reordered");

endmodule
`default_nettype wire
